// ===== hdl/session_history_route_picker_unit_macros.svh =====
// Assertion macros used by the controller of the session history route picker
`ifndef SESSION_HISTORY_ROUTE_PICKER_UNIT_MACROS_SVH
`define SESSION_HISTORY_ROUTE_PICKER_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define SHRP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SHRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/shrp_pkg.sv =====
// Package: types and codes of the session history route picker
package shrp_pkg;
   typedef enum logic [2:0] {
      REQ_INSERT     = 3'd0,
      REQ_ROUTE      = 3'd1,
      REQ_DISCONNECT = 3'd2,
      REQ_ERASE      = 3'd3,
      REQ_SET_ACTIVE = 3'd4
   } req_code_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  session_id;
      logic [15:0] random_fraction;
      logic        active_flag;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] route_session;
      logic       route_found;
      logic [3:0] entry_count;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ROUTE_START,
      ST_ROUTE_MUL,
      ST_ROUTE_SCAN,
      ST_ROUTE_CHECK,
      ST_PURGE,
      ST_RESPOND,
      ST_HOLD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic do_insert;
      logic do_erase;
      logic do_set_active;
      logic route_start;
      logic route_mul;
      logic scan_step;
      logic purge_commit;
      logic purge_start_scan;
      logic purge_start_req;
      logic purge_step;
      logic set_notfound;
      logic set_found;
      logic load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      req_code_type req_code;
      logic         ring_empty;
      logic         scan_done;
      logic         scan_hit;
      logic         hit_active;
      logic         purge_done;
   } dp_status_type;
endpackage

// ===== hdl/shrp_ctrl.sv =====
// Controller state machine of the session history route picker
module shrp_ctrl
   import shrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);
`include "session_history_route_picker_unit_macros.svh"

   state_type state_ff, state_in;
   logic      purge_for_route_ff, purge_for_route_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         purge_for_route_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         purge_for_route_ff <= purge_for_route_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      purge_for_route_in = purge_for_route_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.req_code)
               REQ_ROUTE: state_in = ST_ROUTE_START;
               REQ_DISCONNECT: begin
                  state_in = ST_PURGE;
                  purge_for_route_in = 1'b0;
               end
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_ROUTE_START: state_in = status.ring_empty ? ST_RESPOND : ST_ROUTE_MUL;
         ST_ROUTE_MUL: state_in = ST_ROUTE_SCAN;
         ST_ROUTE_SCAN: state_in = ST_ROUTE_CHECK;
         ST_ROUTE_CHECK: begin
            if (status.scan_hit) begin
               if (status.hit_active) begin
                  state_in = ST_RESPOND;
               end else begin
                  state_in = ST_PURGE;
                  purge_for_route_in = 1'b1;
               end
            end else if (status.scan_done) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_ROUTE_SCAN;
            end
         end
         ST_PURGE: begin
            if (status.purge_done)
               state_in = purge_for_route_ff ? ST_ROUTE_START : ST_RESPOND;
         end
         ST_RESPOND: state_in = ST_HOLD;
         ST_HOLD: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DISPATCH: begin
            cmd.set_notfound = 1'b1;
            unique case (status.req_code)
               REQ_INSERT:     cmd.do_insert = 1'b1;
               REQ_ERASE:      cmd.do_erase = 1'b1;
               REQ_SET_ACTIVE: cmd.do_set_active = 1'b1;
               REQ_DISCONNECT: cmd.purge_start_req = 1'b1;
               default: ;
            endcase
         end
         ST_ROUTE_START: cmd.route_start = 1'b1;
         ST_ROUTE_MUL: cmd.route_mul = 1'b1;
         ST_ROUTE_SCAN: cmd.scan_step = 1'b1;
         ST_ROUTE_CHECK: begin
            if (status.scan_hit && status.hit_active) cmd.set_found = 1'b1;
            if (status.scan_hit && !status.hit_active) cmd.purge_start_scan = 1'b1;
         end
         ST_PURGE: begin
            cmd.purge_step = !status.purge_done;
            // compaction finished: new tail is the write pointer
            cmd.purge_commit = status.purge_done;
         end
         ST_RESPOND: cmd.load_rsp = 1'b1;
         ST_HOLD: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   `SHRP_ASSERT_IMPL(a_ready_only_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `SHRP_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accept while result pending")
   `SHRP_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
endmodule

// ===== hdl/shrp_dpath.sv =====
// Datapath of the session history route picker: ring, activity map, scan and purge
module shrp_dpath
   import shrp_pkg::*;
#(
   parameter int unsigned RING_SIZE = 16,
   parameter int unsigned SESSION_COUNT = 256
)(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_data
);
   localparam int unsigned IdxW = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;
   localparam int unsigned MapW = (SESSION_COUNT > 2) ? $clog2(SESSION_COUNT) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_SIZE - 1);

   function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] i);
      return (i == LastIdx) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                                input logic [IdxW-1:0] b);
      logic [IdxW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= (IdxW+1)'(RING_SIZE)) ? IdxW'(s - (IdxW+1)'(RING_SIZE)) : s[IdxW-1:0];
   endfunction

   logic [7:0] ring_mem [RING_SIZE];
   logic [SESSION_COUNT-1:0] active_ff;

   logic [IdxW-1:0] head_ff, tail_ff;
   req_payload_type req_ff;
   rsp_payload_type rsp_ff;
   logic [7:0]      chosen_ff;
   logic            found_ff;

   logic [IdxW-1:0] used_ff;
   logic [IdxW-1:0] pos_ff, scan_left_ff;
   logic [7:0]      rd_ff;
   logic            rd_valid_ff;
   logic            hit_active_ff;

   logic [7:0]      purge_id_ff;
   logic [IdxW-1:0] prd_ff, pwr_ff;
   logic            purge_done;

   logic [IdxW-1:0] used_now;
   assign used_now = wrap_add(tail_ff, IdxW'(RING_SIZE) - head_ff);

   logic [IdxW+15:0] prod_full;
   assign prod_full = {{IdxW{1'b0}}, req_ff.random_fraction} * {16'd0, used_ff};

   assign purge_done = (prd_ff == tail_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.do_insert) ring_mem[tail_ff] <= req_ff.session_id;
      if (cmd.purge_step && ring_mem[prd_ff] != purge_id_ff)
         ring_mem[pwr_ff] <= ring_mem[prd_ff];
      if (cmd.scan_step) begin
         rd_ff <= ring_mem[pos_ff];
         // activity bit of the id read, registered with it
         hit_active_ff <= (32'(ring_mem[pos_ff]) < SESSION_COUNT) &&
                          active_ff[MapW'(ring_mem[pos_ff])];
      end
      if (cmd.route_start) used_ff <= used_now;
      if (cmd.route_mul) begin
         pos_ff <= wrap_add(head_ff, prod_full[IdxW+15:16]);
         scan_left_ff <= used_ff;
      end
      if (cmd.scan_step) begin
         // logical offset wraps within used entries, i.e. back to head
         pos_ff <= (wrap_inc(pos_ff) == tail_ff) ? head_ff : wrap_inc(pos_ff);
         scan_left_ff <= scan_left_ff - 1'b1;
      end
      if (cmd.purge_start_scan) purge_id_ff <= rd_ff;
      if (cmd.purge_start_req) purge_id_ff <= req_ff.session_id;
      if (cmd.purge_start_scan || cmd.purge_start_req) begin
         prd_ff <= head_ff;
         pwr_ff <= head_ff;
      end
      if (cmd.purge_step) begin
         prd_ff <= wrap_inc(prd_ff);
         if (ring_mem[prd_ff] != purge_id_ff) pwr_ff <= wrap_inc(pwr_ff);
      end
      if (cmd.set_notfound) begin
         found_ff <= 1'b0;
         chosen_ff <= '0;
      end
      if (cmd.set_found) begin
         found_ff <= 1'b1;
         chosen_ff <= rd_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff.route_session <= chosen_ff;
         rsp_ff.route_found <= found_ff;
         rsp_ff.entry_count <= 4'(used_now);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         active_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
         if (cmd.do_insert) begin
            tail_ff <= wrap_inc(tail_ff);
            if (wrap_inc(tail_ff) == head_ff) head_ff <= wrap_inc(head_ff);
         end
         if (cmd.do_erase) begin
            head_ff <= '0;
            tail_ff <= '0;
         end
         if (cmd.do_set_active && 32'(req_ff.session_id) < SESSION_COUNT)
            active_ff[MapW'(req_ff.session_id)] <= req_ff.active_flag;
         if (cmd.purge_commit) tail_ff <= pwr_ff;
      end
   end

   assign status.req_code   = req_code_type'(req_ff.req_type);
   assign status.ring_empty = (used_now == '0);
   assign status.scan_hit   = rd_valid_ff && (rd_ff != req_ff.session_id);
   assign status.scan_done  = (scan_left_ff == '0);
   assign status.hit_active = hit_active_ff;
   assign status.purge_done = purge_done;
   assign rsp_data = rsp_ff;
endmodule

// ===== hdl/session_history_route_picker_unit.sv =====
// Top level of the session history route picker
// Usage:
//  req_ channel carries one request (insert, route, disconnect, erase,
//  set active flag) per transfer; rsp_ channel returns one result per request.
//  One request is in flight at a time; req_ready is high only when idle.
//  Steps from the request transfer: insert, erase, set-active and unknown
//  requests pass dispatch, then respond, and rsp_valid rises in hold.
//  Disconnect passes dispatch, then a purge whose compaction examines one ring
//  entry per cycle and commits the new tail once it reaches the old tail.
//  A route passes dispatch and, per pass, a setup of count and offset
//  multiply, then a scan that reads and checks each entry in turn; each pass
//  that hits an inactive id adds a purge of that id, then the route restarts.
//  An empty ring or the end of the route goes to respond.
//  A new request can transfer in the cycle after the result transfers; the
//  block takes no new request before the last result has gone.
//  Reset clears head, tail and all activity flags; ring contents are not
//  cleared since no read reaches unwritten slots.
//  When the receiver stalls, the result is held in its register with
//  rsp_valid high, and no new request is taken until it transfers.
module session_history_route_picker_unit
   import shrp_pkg::*;
#(
   parameter int unsigned RING_SIZE = 16,
   parameter int unsigned SESSION_COUNT = 256
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);
   dp_cmd_type    cmd;
   dp_status_type status;

   shrp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   shrp_dpath #(.RING_SIZE(RING_SIZE), .SESSION_COUNT(SESSION_COUNT)) u_dpath (
      .clock(clock), .reset(reset),
      .req_data(req_data), .cmd(cmd),
      .status(status), .rsp_data(rsp_data)
   );
endmodule
